// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files of the sieve block.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/osieve_pkg.sv -----
// Package of the odd segment sieve: field widths, command codes and sequencer states.
// Used by the core and by its port checker; depends on nothing.
`default_nettype none

package osieve_pkg;

  localparam int SEGMENT_ODDS_DEF = 65536;
  localparam int BASE_W           = 62;
  localparam int PRIME_W          = 32;
  localparam int WIDX_W           = 10;
  localparam int MASK_W           = 64;
  localparam int CMD_W            = 2;
  localparam int IN_DATA_W        = 48;
  localparam int IN_USER_W        = 8;
  localparam int OUT_DATA_W       = 64;
  localparam int OUT_USER_W       = 8;
  // Map index width: enough to hold an index started up to two primes past zero.
  localparam int IDX_W            = PRIME_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_STRIKE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_IDX,
    S_SELF,
    S_ADD,
    S_WLK,
    S_WR,
    S_CLR,
    S_RD,
    S_RDD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/odd_segment_sieve_core.sv -----
// Segmented odd-only sieve: candidate map memory, shared 33-bit adder and its sequencer.
// Depends on osieve_pkg.
`default_nettype none

// A clear writes every map word in turn, a read fetches one word, other commands go straight to the result.
// A strike takes base mod p on the shared subtractor, then the start index, then a
// read-modify-write on the single memory port for each struck entry. The result
// shows in the same cycle as the block is ready again; one request at a time.
// Reset clears control state and sets the base to 1; the map reads as all zeros until
// the first clear command, which rewrites every word, so no clearing pass is needed.
module odd_segment_sieve_core
  import osieve_pkg::*;
#(
  parameter int SEGMENT_ODDS = SEGMENT_ODDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] prime, [41:32] word_index
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [1:0] cmd
  // Result channel.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [63:0] word_mask
  output logic [OUT_USER_W-1:0]      out_tuser,  // [1:0] done_kind
  // Segment base register.
  input  wire logic                  cfg_we,
  input  wire logic [BASE_W-1:0]     cfg_wdata
);

  localparam int MAP_WORDS = (SEGMENT_ODDS + 63) / 64;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LAST_BITS = SEGMENT_ODDS % 64;

  // Candidate map memory and its registered read data.
  logic [MASK_W-1:0] map_mem [MAP_WORDS];
  logic [MASK_W-1:0] rdata_r;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [MASK_W-1:0] mem_wdata;

  // Sequencer and datapath registers.
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [PRIME_W-1:0]  prime_r, prime_nxt;
  logic [WIDX_W-1:0]   widx_r, widx_nxt;
  logic [BASE_W-1:0]   base_r;
  logic [BASE_W-1:0]   base_sh_r, base_sh_nxt;
  logic [PRIME_W-1:0]  rem_r, rem_nxt;
  logic [5:0]          step_r, step_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic                map_valid_r, map_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  cmd_t                out_kind_r, out_kind_nxt;

  // Shared add/subtract unit.
  logic [IDX_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [IDX_W:0]   alu_res;

  logic [BASE_W-1:0] odd_base;
  logic              base_is_one;
  logic [IDX_W-1:0]  rem_shift;
  logic [MASK_W-1:0] clear_word;
  cmd_t              in_cmd;
  logic [PRIME_W-1:0] in_prime;
  logic [WIDX_W-1:0] in_widx;

  assign odd_base    = {base_r[BASE_W-1:1], 1'b1};
  assign base_is_one = (base_r[BASE_W-1:1] == '0);
  assign rem_shift   = {rem_r, base_sh_r[BASE_W-1]};
  assign in_cmd      = cmd_t'(in_tuser[CMD_W-1:0]);
  assign in_prime    = in_tdata[PRIME_W-1:0];
  assign in_widx     = in_tdata[PRIME_W +: WIDX_W];

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (IDX_W+1)'(alu_sub);

  // Operand selection for the shared unit; a carry out on subtract means no borrow.
  always_comb begin
    alu_a   = {1'b0, prime_r};
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_MOD: begin
        alu_a = rem_shift;
        alu_b = {1'b0, prime_r};
      end
      S_IDX: begin
        alu_b = rem_r[0] ? {1'b0, rem_r} : {2'b00, rem_r[PRIME_W-1:1]};
      end
      S_SELF: begin
        alu_b = {1'b0, odd_base[PRIME_W-1:0]};
      end
      S_ADD, S_WR: begin
        alu_a   = i_r;
        alu_b   = {1'b0, prime_r};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = {1'b0, prime_r};
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  // Word written by a clear: all candidates, less the tail past the segment and the value 1.
  always_comb begin
    clear_word = '1;
    if ((LAST_BITS != 0) && (cnt_r == AW'(MAP_WORDS - 1))) begin
      clear_word = ~({MASK_W{1'b1}} << LAST_BITS);
    end
    if ((cnt_r == '0) && base_is_one) begin
      clear_word[0] = 1'b0;
    end
  end

  // Sequencer: next state, datapath updates and memory control.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    prime_nxt     = prime_r;
    widx_nxt      = widx_r;
    base_sh_nxt   = base_sh_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    map_valid_nxt = map_valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mask_nxt  = out_mask_r;
    out_kind_nxt  = out_kind_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = rdata_r & ~(MASK_W'(1) << i_r[5:0]);
    mem_addr      = i_r[6 +: AW];

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt     = in_cmd;
          prime_nxt   = in_prime;
          widx_nxt    = in_widx;
          mask_nxt    = '0;
          cnt_nxt     = '0;
          step_nxt    = '0;
          rem_nxt     = '0;
          base_sh_nxt = odd_base;
          unique case (in_cmd)
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_STRIKE: begin
              if (!in_prime[0] || (in_prime[PRIME_W-1:1] == '0)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_MOD;
              end
            end
            CMD_READ: begin
              if (map_valid_r && (32'(in_widx) < MAP_WORDS)) begin
                state_nxt = S_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // One remainder bit per cycle, base taken from the top down.
      S_MOD: begin
        rem_nxt     = alu_res[IDX_W] ? alu_res[PRIME_W-1:0] : rem_shift[PRIME_W-1:0];
        base_sh_nxt = {base_sh_r[BASE_W-2:0], 1'b0};
        step_nxt    = step_r + 6'd1;
        if (step_r == 6'(BASE_W - 1)) begin
          state_nxt = S_IDX;
        end
      end

      // Index of the first odd multiple at or above the base.
      S_IDX: begin
        if (rem_r == '0) begin
          i_nxt = '0;
        end else if (rem_r[0]) begin
          i_nxt = {1'b0, alu_res[IDX_W-1:1]};
        end else begin
          i_nxt = alu_res[IDX_W-1:0];
        end
        state_nxt = S_SELF;
      end

      // That multiple is the prime itself exactly when the base does not exceed it.
      S_SELF: begin
        if ((odd_base[BASE_W-1:PRIME_W] == '0) && alu_res[IDX_W]) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_WLK;
        end
      end

      S_ADD: begin
        i_nxt     = alu_res[IDX_W-1:0];
        state_nxt = S_WLK;
      end

      // Fetch the word holding the next entry to strike.
      S_WLK: begin
        if (i_r < IDX_W'(SEGMENT_ODDS)) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_WR: begin
        mem_we    = 1'b1;
        i_nxt     = alu_res[IDX_W-1:0];
        state_nxt = S_WLK;
      end

      S_CLR: begin
        mem_addr  = cnt_r;
        mem_we    = 1'b1;
        mem_wdata = clear_word;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(MAP_WORDS - 1)) begin
          map_valid_nxt = 1'b1;
          state_nxt     = S_DONE;
        end
      end

      S_RD: begin
        mem_addr  = AW'(widx_r);
        state_nxt = S_RDD;
      end

      S_RDD: begin
        mask_nxt  = rdata_r;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_r;
          out_kind_nxt  = cmd_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_W'(1);
    end else begin
      state_r     <= state_nxt;
      map_valid_r <= map_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    prime_r    <= prime_nxt;
    widx_r     <= widx_nxt;
    base_sh_r  <= base_sh_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    i_r        <= i_nxt;
    cnt_r      <= cnt_nxt;
    mask_r     <= mask_nxt;
    out_mask_r <= out_mask_nxt;
    out_kind_r <= out_kind_nxt;
  end

  // Map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= map_mem[mem_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = {{(OUT_USER_W-CMD_W){1'b0}}, out_kind_r};

endmodule

`default_nettype wire

// ----- design/osieve_chk.sv -----
// Port checker of the odd segment sieve core, bound to its top level.
// Depends on osieve_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module osieve_chk
  import osieve_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  // A result that is not taken stays put.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Only a read returns map bits.
  `ASSERT_CLK(a_mask_zero, !(out_tvalid && (out_tuser[CMD_W-1:0] != CMD_READ) && (out_tdata != '0)), "nonzero mask on a non-read result")

  // The block works one request at a time.
  `ASSERT_NEXT(a_one_at_time, in_tvalid && in_tready, !in_tready, "request accepted while busy")

  // A new result never becomes valid on the clock edge that takes a request.
  `ASSERT_NEXT(a_no_instant, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result without any work cycle")

endmodule

bind odd_segment_sieve_core osieve_chk u_osieve_chk (.*);

`default_nettype wire
